// ----- rtl/tspc_pkg.sv -----
// tspc_pkg: shared types and constants of the stepper pulse controller
// used by the divider, the controller top level and its checker
package tspc_pkg;

    localparam int DIVIDEND_W = 20;
    localparam int DIVISOR_W  = 16;
    localparam int CNT_W      = 5;
    localparam int VEL_W      = 16;
    localparam int OP_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam logic [DIVIDEND_W-1:0] STEP_CLOCK_HZ = 20'd1000000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 4'd0,
        OP_ENABLE    = 4'd1,
        OP_DISABLE   = 4'd2,
        OP_ESTOP     = 4'd3,
        OP_SET_HOME  = 4'd4,
        OP_ROT_ABS   = 4'd5,
        OP_ROT_REL   = 4'd6,
        OP_ROT_HOME  = 4'd7,
        OP_ROT_LOWER = 4'd8,
        OP_ROT_UPPER = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        RUN_DISABLED = 2'd0,
        RUN_ENABLED  = 2'd1,
        RUN_RUNNING  = 2'd2,
        RUN_ESTOP    = 2'd3
    } t_run;

    typedef enum logic [2:0] {
        STAT_OKAY         = 3'd0,
        STAT_RUN_COMPLETE = 3'd1,
        STAT_RANGE_LOWER  = 3'd2,
        STAT_RANGE_UPPER  = 3'd3,
        STAT_SWITCH_LOWER = 3'd4,
        STAT_SWITCH_UPPER = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_LOWER_LIMIT  = 3'd0,
        CFG_UPPER_LIMIT  = 3'd1,
        CFG_RAMP_SETTING = 3'd2,
        CFG_RAMP_SCALE   = 3'd3,
        CFG_HOMING_SPEED = 3'd4,
        CFG_LOWER_SW     = 3'd5,
        CFG_UPPER_SW     = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_TICK_CHK,
        SEQ_TICK_RAMP,
        SEQ_TICK_NEXT,
        SEQ_TICK_DIV,
        SEQ_ROT_TGT,
        SEQ_ROT_LEN,
        SEQ_ROT_DIV,
        SEQ_ROT_END,
        SEQ_DONE
    } t_seq;

endpackage

// ----- rtl/tspc_div.sv -----
// tspc_div: shared restoring divider, one quotient bit per cycle
// depends on tspc_pkg for operand widths
module tspc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tspc_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [tspc_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [tspc_pkg::DIVIDEND_W-1:0] o_quotient
);
    import tspc_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the difference fits
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = diff[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/trapezoid_stepper_pulse_controller.sv -----
// trapezoid_stepper_pulse_controller: motion profile sequencer for one stepper
// depends on tspc_pkg and the shared divider tspc_div
//
// Usage: every request on the slave stream is either a one-microsecond tick
// (operation 0 on tuser) or a command. Each request gives exactly one result
// on the master stream with status, step pulse, pins, state and positions.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data, a
// write landing at the clock edge with i_cfg_we high; the user must write
// them only while the block is idle; the block itself does not enforce it.
// A command or a tick that does not step skips the divider; a stepping tick
// at positive velocity that keeps running, or a rotate with a nonzero ramp
// increment, runs the shared 20-bit divider, one quotient bit per cycle. It
// sets step interval (1000000/velocity) and ramp length (speed/increment).
// One request is in work at a time; o_s_tready is high only while the
// sequencer is idle. The result register holds a finished result while the
// receiver stalls; the next request is still taken and waits to be written
// until the register is free.
// Reset (synchronous, active low) clears the motion state to disabled,
// not homed, position zero, and loads the register defaults.
module trapezoid_stepper_pulse_controller #(
    parameter int POSITION_WIDTH       = 32,
    parameter int TIME_WIDTH           = 32,
    parameter int DIRECTION_LEAD_TICKS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave tdata: target_value[31:0], speed[45:32], lower_switch_hit[46],
    // upper_switch_hit[47]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tspc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // slave tuser: operation[3:0]
    input  logic [tspc_pkg::OP_W-1:0]       i_s_tuser,
    // master tdata: status[2:0], step_pulse[3], direction[4],
    // driver_enabled[5], motor_state[7:6], homed_flag[8],
    // absolute_position[40:9], relative_position[72:41], zero fill
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tspc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [tspc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tspc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tspc_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int EW = ((PW > 32) ? PW : 32) + 2;
    localparam logic signed [EW-1:0] PMAX = {{(EW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [EW-1:0] PMIN = ~PMAX;

    // configuration
    logic signed [31:0] r_lower;
    logic [30:0]        r_upper;
    logic [3:0]         r_rset;
    logic [9:0]         r_rscale;
    logic [13:0]        r_hspd;
    logic               r_lsp, r_usp;

    // motion state
    t_seq                  r_seq, n_seq;
    logic [TW-1:0]         r_time, n_time;
    logic [TW-1:0]         r_nst, n_nst;
    t_run                  r_run, n_run;
    logic                  r_homed, n_homed;
    logic                  r_en, n_en;
    logic                  r_neg, n_neg;
    logic signed [PW-1:0]  r_pos, n_pos;
    logic signed [PW-1:0]  r_target, n_target;
    logic signed [EW-1:0]  r_moved, n_moved;
    logic signed [VEL_W-1:0] r_vel, n_vel;
    logic [PW-1:0]         r_rus, n_rus;
    logic [PW-1:0]         r_rds, n_rds;

    // work registers
    logic                  r_lh, n_lh;
    logic                  r_uh, n_uh;
    logic signed [EW-1:0]  r_np, n_np;
    logic signed [EW-1:0]  r_raw, n_raw;
    logic [13:0]           r_maxv, n_maxv;
    logic [PW-1:0]         r_total, n_total;
    t_status               r_status, n_status;
    logic                  r_pulse, n_pulse;
    logic                  r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    // divider
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_q;

    // combinational helpers
    t_op                   in_op;
    logic signed [31:0]    in_tv;
    logic                  in_acc;
    logic signed [EW-1:0]  pos_e, tgt_e, tv_e, lower_e, upper_e, lo_e, hi_e;
    logic signed [EW-1:0]  diff_e;
    logic [3:0]            rset_c;
    logic [13:0]           inc;
    logic [EW-1:0]         k_abs;
    logic signed [VEL_W+1:0] v_next;
    logic [TW+DIVIDEND_W-1:0] q_time;
    logic [PW+DIVIDEND_W-1:0] q_pos;
    logic                  out_free;

    tspc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign in_op    = t_op'(i_s_tuser);
    assign in_tv    = i_s_tdata[31:0];
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;

    assign pos_e   = {{(EW-PW){r_pos[PW-1]}}, r_pos};
    assign tgt_e   = {{(EW-PW){r_target[PW-1]}}, r_target};
    assign tv_e    = {{(EW-32){in_tv[31]}}, in_tv};
    assign lower_e = {{(EW-32){r_lower[31]}}, r_lower};
    assign upper_e = {{(EW-31){1'b0}}, r_upper};
    assign lo_e    = (lower_e > PMIN) ? lower_e : PMIN;
    assign hi_e    = (upper_e < PMAX) ? upper_e : PMAX;
    assign rset_c  = (r_rset > 4'd9) ? 4'd9 : r_rset;
    assign inc     = (rset_c == 4'd0) ? 14'd0
                   : 14'(r_rscale) * 14'(4'd10 - rset_c);
    assign k_abs   = (r_moved < 0) ? EW'(-r_moved) : EW'(r_moved);
    assign q_time  = {{TW{1'b0}}, div_q};
    assign q_pos   = {{PW{1'b0}}, div_q};

    always_comb begin
        n_seq    = r_seq;
        n_time   = r_time;
        n_nst    = r_nst;
        n_run    = r_run;
        n_homed  = r_homed;
        n_en     = r_en;
        n_neg    = r_neg;
        n_pos    = r_pos;
        n_target = r_target;
        n_moved  = r_moved;
        n_vel    = r_vel;
        n_rus    = r_rus;
        n_rds    = r_rds;
        n_lh     = r_lh;
        n_uh     = r_uh;
        n_np     = r_np;
        n_raw    = r_raw;
        n_maxv   = r_maxv;
        n_total  = r_total;
        n_status = r_status;
        n_pulse  = r_pulse;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;
        div_start    = 1'b0;
        div_dividend = STEP_CLOCK_HZ;
        div_divisor  = r_vel;
        diff_e   = '0;
        v_next   = '0;

        unique case (r_seq)
            SEQ_IDLE: begin
                if (in_acc) begin
                    n_lh     = i_s_tdata[46];
                    n_uh     = i_s_tdata[47];
                    n_status = STAT_OKAY;
                    n_pulse  = 1'b0;
                    n_seq    = SEQ_DONE;
                    n_maxv   = r_hspd;
                    unique case (in_op)
                        OP_TICK: begin
                            n_time = r_time + TW'(1);
                            n_np   = r_neg ? pos_e - EW'(1) : pos_e + EW'(1);
                            if (r_homed && r_run == RUN_RUNNING && r_time >= r_nst) begin
                                if (r_pos == r_target) begin
                                    n_run    = RUN_ENABLED;
                                    n_status = STAT_RUN_COMPLETE;
                                end else begin
                                    n_seq = SEQ_TICK_CHK;
                                end
                            end
                        end
                        OP_ENABLE: begin
                            n_en    = 1'b1;
                            n_run   = RUN_ENABLED;
                            n_pos   = '0;
                            n_moved = '0;
                            n_homed = 1'b1;
                        end
                        OP_DISABLE: begin
                            n_en    = 1'b0;
                            n_run   = RUN_DISABLED;
                            n_homed = 1'b0;
                        end
                        OP_ESTOP: begin
                            n_en     = 1'b0;
                            n_run    = RUN_ESTOP;
                            n_homed  = 1'b0;
                            n_target = r_pos;
                        end
                        OP_SET_HOME: begin
                            if (r_run == RUN_ENABLED) begin
                                n_pos   = '0;
                                n_moved = '0;
                                n_homed = 1'b1;
                            end
                        end
                        OP_ROT_ABS: begin
                            n_raw  = tv_e;
                            n_maxv = i_s_tdata[45:32];
                            n_seq  = SEQ_ROT_TGT;
                        end
                        OP_ROT_REL: begin
                            n_raw  = pos_e + tv_e;
                            n_maxv = i_s_tdata[45:32];
                            if (in_tv != 0) begin
                                n_seq = SEQ_ROT_TGT;
                            end
                        end
                        OP_ROT_HOME: begin
                            n_raw = '0;
                            n_seq = SEQ_ROT_TGT;
                        end
                        OP_ROT_LOWER: begin
                            n_raw = lower_e;
                            n_seq = SEQ_ROT_TGT;
                        end
                        OP_ROT_UPPER: begin
                            n_raw = upper_e;
                            n_seq = SEQ_ROT_TGT;
                        end
                        default: begin
                            n_seq = SEQ_DONE;
                        end
                    endcase
                end
            end
            SEQ_TICK_CHK: begin
                n_seq = SEQ_DONE;
                if (r_np < lo_e) begin
                    n_run    = RUN_ENABLED;
                    n_status = STAT_RANGE_LOWER;
                end else if (r_np > hi_e) begin
                    n_run    = RUN_ENABLED;
                    n_status = STAT_RANGE_UPPER;
                end else begin
                    n_pulse = 1'b1;
                    n_pos   = r_np[PW-1:0];
                    n_moved = r_neg ? r_moved - EW'(1) : r_moved + EW'(1);
                    if (r_lsp && r_lh) begin
                        n_run    = RUN_ENABLED;
                        n_status = STAT_SWITCH_LOWER;
                    end else if (r_usp && r_uh) begin
                        n_run    = RUN_ENABLED;
                        n_status = STAT_SWITCH_UPPER;
                    end else begin
                        n_seq = SEQ_TICK_RAMP;
                    end
                end
            end
            SEQ_TICK_RAMP: begin
                // accelerate inside the ramp-up, brake past the ramp-down start
                if (k_abs <= {{(EW-PW){1'b0}}, r_rus}) begin
                    v_next = {{2{r_vel[VEL_W-1]}}, r_vel} + {4'b0, inc};
                end else if (k_abs > {{(EW-PW){1'b0}}, r_rds}) begin
                    v_next = {{2{r_vel[VEL_W-1]}}, r_vel} - {4'b0, inc};
                end else begin
                    v_next = {{2{r_vel[VEL_W-1]}}, r_vel};
                end
                if (v_next > 18'sd32767) begin
                    n_vel = 16'sh7fff;
                end else if (v_next < -18'sd32768) begin
                    n_vel = 16'sh8000;
                end else begin
                    n_vel = v_next[VEL_W-1:0];
                end
                n_seq = SEQ_TICK_NEXT;
            end
            SEQ_TICK_NEXT: begin
                if (r_vel > 0) begin
                    div_start = 1'b1;
                    n_seq     = SEQ_TICK_DIV;
                end else begin
                    n_seq = SEQ_DONE;
                end
            end
            SEQ_TICK_DIV: begin
                if (div_done) begin
                    n_nst = r_nst + q_time[TW-1:0];
                    n_seq = SEQ_DONE;
                end
            end
            SEQ_ROT_TGT: begin
                if (r_raw > PMAX) begin
                    n_target = PMAX[PW-1:0];
                end else if (r_raw < PMIN) begin
                    n_target = PMIN[PW-1:0];
                end else begin
                    n_target = r_raw[PW-1:0];
                end
                n_seq = SEQ_ROT_LEN;
            end
            SEQ_ROT_LEN: begin
                diff_e  = (tgt_e >= pos_e) ? tgt_e - pos_e : pos_e - tgt_e;
                n_total = diff_e[PW-1:0];
                n_neg   = tgt_e < pos_e;
                div_dividend = {{(DIVIDEND_W-14){1'b0}}, r_maxv};
                div_divisor  = {{(DIVISOR_W-14){1'b0}}, inc};
                if (inc == 14'd0) begin
                    n_rus = '0;
                    n_vel = {2'b00, r_maxv};
                    n_seq = SEQ_ROT_END;
                end else begin
                    div_start = 1'b1;
                    n_seq     = SEQ_ROT_DIV;
                end
            end
            SEQ_ROT_DIV: begin
                if (div_done) begin
                    n_rus = q_pos[PW-1:0];
                    n_vel = (div_q == '0) ? {2'b00, r_maxv} : '0;
                    n_seq = SEQ_ROT_END;
                end
            end
            SEQ_ROT_END: begin
                // triangle profile when the move is too short for both ramps
                if ({1'b0, r_total} > {r_rus, 1'b0}) begin
                    n_rds = r_total - r_rus;
                end else begin
                    n_rus = r_total >> 1;
                    n_rds = r_total >> 1;
                end
                n_moved = '0;
                n_nst   = r_time + TW'(DIRECTION_LEAD_TICKS);
                n_run   = RUN_RUNNING;
                n_seq   = SEQ_DONE;
            end
            SEQ_DONE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {{(OUT_DATA_W-73){1'b0}}, r_moved[31:0], pos_e[31:0],
                                r_homed, r_run, r_en, r_neg, r_pulse, r_status};
                    n_seq    = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= SEQ_IDLE;
            r_ovalid <= 1'b0;
            r_time   <= '0;
            r_nst    <= '1;
            r_run    <= RUN_DISABLED;
            r_homed  <= 1'b0;
            r_en     <= 1'b0;
            r_neg    <= 1'b0;
            r_pos    <= '0;
            r_target <= '0;
            r_moved  <= '0;
            r_vel    <= '0;
            r_rus    <= '0;
            r_rds    <= '0;
            r_lower  <= -32'sd2000000000;
            r_upper  <= 31'd2000000000;
            r_rset   <= 4'd5;
            r_rscale <= 10'd100;
            r_hspd   <= 14'd1000;
            r_lsp    <= 1'b0;
            r_usp    <= 1'b0;
        end else begin
            r_seq    <= n_seq;
            r_ovalid <= n_ovalid;
            r_time   <= n_time;
            r_nst    <= n_nst;
            r_run    <= n_run;
            r_homed  <= n_homed;
            r_en     <= n_en;
            r_neg    <= n_neg;
            r_pos    <= n_pos;
            r_target <= n_target;
            r_moved  <= n_moved;
            r_vel    <= n_vel;
            r_rus    <= n_rus;
            r_rds    <= n_rds;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LOWER_LIMIT:  r_lower  <= i_cfg_data;
                    CFG_UPPER_LIMIT:  r_upper  <= i_cfg_data[30:0];
                    CFG_RAMP_SETTING: r_rset   <= i_cfg_data[3:0];
                    CFG_RAMP_SCALE:   r_rscale <= i_cfg_data[9:0];
                    CFG_HOMING_SPEED: r_hspd   <= i_cfg_data[13:0];
                    CFG_LOWER_SW:     r_lsp    <= i_cfg_data[0];
                    CFG_UPPER_SW:     r_usp    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_lh     <= n_lh;
        r_uh     <= n_uh;
        r_np     <= n_np;
        r_raw    <= n_raw;
        r_maxv   <= n_maxv;
        r_total  <= n_total;
        r_status <= n_status;
        r_pulse  <= n_pulse;
        r_odata  <= n_odata;
    end

    assign o_s_tready = (r_seq == SEQ_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

// ----- rtl/tspc_checker.sv -----
// tspc_checker: port-level assertions for the stepper pulse controller
// depends on tspc_pkg; bound to the top level below
module tspc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [tspc_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import tspc_pkg::*;

    // an accepted request drops input ready in the following cycle
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a request");

    // a step is only issued with okay or switch status
    a_pulse_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3]) |->
        (o_m_tdata[2:0] == STAT_OKAY || o_m_tdata[2:0] == STAT_SWITCH_LOWER ||
         o_m_tdata[2:0] == STAT_SWITCH_UPPER))
        else $error("step pulse with a stop status");

    // no step while the driver is off
    a_no_pulse_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[5]) |-> !o_m_tdata[3])
        else $error("step pulse with driver disabled");

    // the disabled state never shows the driver enabled
    a_disabled_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[7:6] == RUN_DISABLED) |-> !o_m_tdata[5])
        else $error("driver enabled in disabled state");

    // a stalled result stays presented
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result dropped under stall");

endmodule

bind trapezoid_stepper_pulse_controller tspc_checker u_tspc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
